FILE: rtl/motion_link_reply_parser_top_macros.svh
// Assertion helpers used by the parser top module.
`ifndef MOTION_LINK_REPLY_PARSER_TOP_MACROS_SVH
`define MOTION_LINK_REPLY_PARSER_TOP_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MLRP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MLRP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/mlrp_pkg.sv
package mlrp_pkg;

   // Command bytes sent by the motion controller
   localparam logic [7:0] CMD_DONE      = 8'h00;
   localparam logic [7:0] CMD_TEST      = 8'h86;
   localparam logic [7:0] CMD_POS       = 8'h87;
   localparam logic [7:0] CMD_COEF_A    = 8'h8E;
   localparam logic [7:0] CMD_COEF_B    = 8'h8F;
   localparam logic [7:0] CMD_COEF_C    = 8'h90;
   localparam logic [7:0] CMD_GET_CMD   = 8'h92;
   localparam logic [7:0] CMD_LINK_TEST = 8'h93;
   localparam logic [7:0] CMD_ACK       = 8'h94;
   localparam logic [7:0] CMD_MIN_SPEED = 8'h96;

   // First get-command payload byte: motion kind
   localparam logic [7:0] LIMIT_ALPHA = 8'h80;
   localparam logic [7:0] KIND_FAST   = 8'h80;
   localparam logic [7:0] KIND_CURVE  = 8'h81;

   // Payload lengths and indexes
   localparam logic [3:0] POS_LEN         = 4'd6;
   localparam logic [3:0] COEF_LEN        = 4'd2;
   localparam logic [3:0] GET_LEN         = 4'd9;
   localparam logic [3:0] GET_FIRST_INDEX = 4'd8;
   localparam logic [3:0] GET_SHORT_LEFT  = 4'd3;

   localparam logic [15:0] DONE_MAX = 16'hFFFF;

   // Debug mark codes
   localparam logic [1:0] MARK_NONE    = 2'd0;
   localparam logic [1:0] MARK_RESTART = 2'd1;
   localparam logic [1:0] MARK_LINK    = 2'd2;

   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [3:0]  bytes_left;
      logic [7:0]  command;
      logic        ready;
      logic        halt;
      logic [15:0] done_cnt;
   } state_type;

   typedef struct packed {
      logic        store_valid;
      logic [3:0]  store_index;
      logic [7:0]  store_byte;
      logic        frame_done;
      logic [7:0]  frame_command;
      logic        send_ack;
      logic [1:0]  debug_mark;
      logic        ready_res;
      logic        halted;
      logic [15:0] done_count;
   } result_type;

endpackage

FILE: rtl/mlrp_decode.sv
module mlrp_decode (
   input  logic [7:0]          rx_byte,
   input  mlrp_pkg::state_type cur_state,
   output mlrp_pkg::state_type nxt_state,
   output mlrp_pkg::result_type result
);
   import mlrp_pkg::*;

   // Payload countdown or command decode for one byte
   always_comb begin
      logic [3:0] left_dec;
      left_dec  = cur_state.bytes_left - 4'd1;
      nxt_state = cur_state;
      result    = '0;
      if (!cur_state.halt) begin
         if (cur_state.bytes_left != 4'd0) begin
            nxt_state.bytes_left = left_dec;
            result.store_valid   = 1'b1;
            result.store_index   = left_dec;
            result.store_byte    = rx_byte;
            // get-command: first payload byte picks the frame length
            if (cur_state.command == CMD_GET_CMD && left_dec == GET_FIRST_INDEX) begin
               if (rx_byte < LIMIT_ALPHA) begin
                  nxt_state.bytes_left = GET_SHORT_LEFT;
               end else if (rx_byte != KIND_FAST && rx_byte != KIND_CURVE) begin
                  nxt_state.bytes_left = 4'd0;
               end
            end
            result.frame_done = (nxt_state.bytes_left == 4'd0);
         end else begin
            nxt_state.command = rx_byte;
            unique case (rx_byte)
               CMD_TEST: begin
                  result.send_ack = 1'b1;
                  if (cur_state.ready) begin
                     result.debug_mark = MARK_RESTART;
                     nxt_state.halt    = 1'b1;
                  end
                  nxt_state.ready = 1'b1;
               end
               CMD_ACK: begin
                  nxt_state.ready = 1'b1;
               end
               CMD_POS: begin
                  nxt_state.bytes_left = POS_LEN;
               end
               CMD_DONE: begin
                  if (cur_state.done_cnt != DONE_MAX) begin
                     nxt_state.done_cnt = cur_state.done_cnt + 16'd1;
                  end
               end
               CMD_LINK_TEST: begin
                  result.debug_mark = MARK_LINK;
               end
               CMD_COEF_A, CMD_COEF_B, CMD_COEF_C, CMD_MIN_SPEED: begin
                  nxt_state.bytes_left = COEF_LEN;
               end
               CMD_GET_CMD: begin
                  nxt_state.bytes_left = GET_LEN;
               end
               default: begin
               end
            endcase
         end
      end
      // status fields show the state after this byte
      result.frame_command = nxt_state.command;
      result.ready_res     = nxt_state.ready;
      result.halted        = nxt_state.halt;
      result.done_count    = nxt_state.done_cnt;
   end

endmodule

FILE: rtl/motion_link_reply_parser_top.sv
// Channel  | Dir | Payload
// req_     | in  | tdata[7:0] rx_byte
// rsp_     | out | tdata 48 bits (see port), tlast = frame_done
//
// One byte per cycle sustained while the rsp_ side does not stall.
// Path: input register, decode against the parser state, result register.
// Parser state advances when a byte moves from the input to the result register.
// reset is synchronous, active high; it clears state and both valid bits.
// A stalled rsp_ side holds the result; req_tready falls once both stages are full.
`include "motion_link_reply_parser_top_macros.svh"

module motion_link_reply_parser_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] rx_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] store_valid, [4:1] store_index, [12:5] store_byte, [20:13] frame_command,
   // [21] send_ack, [23:22] debug_mark, [24] ready_res, [25] halted,
   // [41:26] done_count, [47:42] zero
   output logic [mlrp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast   // frame_done
);
   import mlrp_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff, out_in;
   state_type  state_ff, state_in;
   state_type  dec_state;
   result_type dec_result;
   logic       out_free;
   logic       advance;

   // Handshake: result register frees when empty or taken
   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   mlrp_decode u_decode (
      .rx_byte   (in_byte_ff),
      .cur_state (state_ff),
      .nxt_state (dec_state),
      .result    (dec_result)
   );

   // Next values of the pipeline and parser state
   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      state_in   = state_ff;
      if (out_free) begin
         out_vld_in = in_vld_ff;
      end
      if (advance) begin
         out_in   = dec_result;
         state_in = dec_state;
      end
      if (req_tready) begin
         in_vld_in  = req_tvalid;
         in_byte_in = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         state_ff   <= state_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   // Result beat packing
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_ff.frame_done;
   assign rsp_tdata  = {6'd0, out_ff.done_count, out_ff.halted, out_ff.ready_res,
                        out_ff.debug_mark, out_ff.send_ack, out_ff.frame_command,
                        out_ff.store_byte, out_ff.store_index, out_ff.store_valid};

   `MLRP_ASSERT_ALWAYS(a_reset_clears, reset |=> !in_vld_ff && !out_vld_ff, "valid after reset")
   `MLRP_ASSERT(a_halt_sticky, state_ff.halt |=> state_ff.halt, "halt cleared without reset")
   `MLRP_ASSERT(a_left_range, state_ff.bytes_left <= GET_LEN, "payload count out of range")
   `MLRP_ASSERT(a_done_is_store, out_vld_ff && out_ff.frame_done |-> out_ff.store_valid, "frame end without payload byte")
   `MLRP_ASSERT(a_halt_quiet, state_ff.halt && advance |=> out_in == out_ff && !out_ff.store_valid && !out_ff.send_ack && out_ff.debug_mark == MARK_NONE, "activity while halted")

endmodule

FILE: dv/tb_motion_link_reply_parser_top.sv
module tb_motion_link_reply_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mlrp_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Parser state as predicted from the accepted bytes
   logic [3:0]  pend_left = '0;
   logic [7:0]  cur_cmd = '0;
   logic        rdy = 1'b0;
   logic        halt_seen = 1'b0;
   logic [15:0] done_total = '0;

   result_type pending_replies[$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   bit         idle_on = 1'b1;
   int         stall_request = 0;

   motion_link_reply_parser_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Expected reply for one received byte; advances the predicted parser state
   function automatic result_type predict_reply(input logic [7:0] b);
      result_type r;
      r = '0;
      if (!halt_seen) begin
         if (pend_left != 0) begin
            pend_left = pend_left - 4'd1;
            r.store_valid = 1'b1;
            r.store_index = pend_left;
            r.store_byte = b;
            // first get-command payload byte picks the frame length
            if (cur_cmd == CMD_GET_CMD && pend_left == GET_FIRST_INDEX) begin
               if (b < LIMIT_ALPHA) pend_left = GET_SHORT_LEFT;
               else if (b != KIND_FAST && b != KIND_CURVE) pend_left = '0;
            end
            r.frame_done = (pend_left == 0);
         end else begin
            cur_cmd = b;
            case (b)
               CMD_TEST: begin
                  r.send_ack = 1'b1;
                  if (rdy) begin
                     r.debug_mark = MARK_RESTART;
                     halt_seen = 1'b1;
                  end
                  rdy = 1'b1;
               end
               CMD_ACK:       rdy = 1'b1;
               CMD_POS:       pend_left = POS_LEN;
               CMD_DONE:      if (done_total != DONE_MAX) done_total = done_total + 16'd1;
               CMD_LINK_TEST: r.debug_mark = MARK_LINK;
               CMD_COEF_A, CMD_COEF_B, CMD_COEF_C, CMD_MIN_SPEED: pend_left = COEF_LEN;
               CMD_GET_CMD:   pend_left = GET_LEN;
               default: ;
            endcase
         end
      end
      r.frame_command = cur_cmd;
      r.ready_res = rdy;
      r.halted = halt_seen;
      r.done_count = done_total;
      return r;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   // Send one byte; random gap first when idling is on
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      pending_replies.push_back(predict_reply(b));
   endtask

   // Random byte that never halts the parser by accident
   function automatic logic [7:0] safe_byte(input logic [7:0] b);
      if (b == CMD_TEST && pend_left == 0 && rdy) return CMD_LINK_TEST;
      return b;
   endfunction

   // Result side: random stalls, plus a long hold-off on request
   initial begin : rsp_side
      int n;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request != 0) begin
            n = stall_request;
            stall_request = 0;
            rsp_tready <= 1'b0;
            while (n > 0) begin
               @(posedge clock);
               n--;
            end
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin : check_beat
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            report_error($sformatf("result beat 0x%0h with no byte pending", rsp_tdata));
         end else begin
            want = pending_replies.pop_front();
            check_field("store_valid", rsp_tdata[0], want.store_valid);
            check_field("store_index", rsp_tdata[4:1], want.store_index);
            check_field("store_byte", rsp_tdata[12:5], want.store_byte);
            check_field("frame_command", rsp_tdata[20:13], want.frame_command);
            check_field("send_ack", rsp_tdata[21], want.send_ack);
            check_field("debug_mark", rsp_tdata[23:22], want.debug_mark);
            check_field("ready_res", rsp_tdata[24], want.ready_res);
            check_field("halted", rsp_tdata[25], want.halted);
            check_field("done_count", rsp_tdata[41:26], want.done_count);
            check_field("pad bits", rsp_tdata[47:42], 0);
            check_field("frame_done", rsp_tlast, want.frame_done);
         end
      end
   end

   // Commands outside any frame, first test while not ready
   task automatic test_commands();
      send_byte(CMD_DONE);
      send_byte(CMD_LINK_TEST);
      send_byte(8'hFF);
      send_byte(CMD_TEST);
      send_byte(CMD_ACK);
   endtask

   // Payload bytes are stored, never decoded
   task automatic test_payload_frames();
      send_byte(CMD_POS);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CMD_TEST);
      send_byte(CMD_POS);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(CMD_COEF_B);
      send_byte(CMD_TEST);
      send_byte(CMD_DONE);
   endtask

   // Short, long and aborted get-command frames
   task automatic test_get_command_lengths();
      send_byte(CMD_GET_CMD);
      send_byte(8'h7F);
      repeat (3) send_byte(8'($urandom_range(0, 255)));
      send_byte(CMD_GET_CMD);
      send_byte(KIND_FAST);
      repeat (8) send_byte(8'($urandom_range(0, 255)));
      send_byte(CMD_GET_CMD);
      send_byte(8'h82);
   endtask

   // Hold the result side off while bytes keep coming
   task automatic test_backpressure();
      idle_on = 1'b0;
      stall_request = 80;
      repeat (24) send_byte(safe_byte(8'($urandom_range(0, 255))));
      idle_on = 1'b1;
   endtask

   // Mostly well-formed frames with random content, some noise
   task automatic test_random_traffic(input int n_items);
      int sent;
      int next_switch;
      int kind;
      int pick;
      logic [7:0] frame[$];
      sent = 0;
      next_switch = 0;
      while (sent < n_items) begin
         if (sent >= next_switch) begin
            idle_on = ($urandom_range(0, 3) != 0);
            next_switch += 150;
         end
         frame.delete();
         kind = $urandom_range(0, 99);
         if (kind < 20) begin
            frame.push_back(CMD_POS);
            repeat (6) frame.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 38) begin
            pick = $urandom_range(0, 3);
            frame.push_back(pick == 0 ? CMD_COEF_A : pick == 1 ? CMD_COEF_B :
                            pick == 2 ? CMD_COEF_C : CMD_MIN_SPEED);
            repeat (2) frame.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 60) begin
            frame.push_back(CMD_GET_CMD);
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
               frame.push_back(8'($urandom_range(0, 8'h7F)));
               repeat (3) frame.push_back(8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
               frame.push_back($urandom_range(0, 1) ? KIND_CURVE : KIND_FAST);
               repeat (8) frame.push_back(8'($urandom_range(0, 255)));
            end else begin
               frame.push_back(8'($urandom_range(8'h82, 8'hFF)));
            end
         end else if (kind < 70) begin
            frame.push_back(CMD_DONE);
         end else if (kind < 75) begin
            frame.push_back(CMD_ACK);
         end else if (kind < 80) begin
            frame.push_back(CMD_LINK_TEST);
         end else begin
            repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
         end
         foreach (frame[i]) begin
            send_byte(safe_byte(frame[i]));
            sent++;
         end
      end
   endtask

   // Back-to-back run of done replies
   task automatic test_done_burst();
      idle_on = 1'b0;
      while (pend_left != 0) send_byte(8'h00);
      repeat (40) send_byte(CMD_DONE);
   endtask

   // First test after the ack halts the parser; everything after is ignored
   task automatic test_halt();
      send_byte(CMD_ACK);
      send_byte(CMD_TEST);
      send_byte(CMD_TEST);
      send_byte(CMD_ACK);
      send_byte(CMD_POS);
      send_byte(CMD_DONE);
      repeat (20) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_commands();
      test_payload_frames();
      test_get_command_lengths();
      test_backpressure();
      test_random_traffic(1200);
      test_done_burst();
      test_halt();

      // drain, then allow the pipeline to settle
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mlrp_pkg.sv
rtl/mlrp_decode.sv
rtl/motion_link_reply_parser_top.sv
dv/tb_motion_link_reply_parser_top.sv
